// ----- design/pet_pkg.sv -----
// ----------------------------------------------------------------------------
// Path expression tokenizer package
// Shared types, character codes and limits for the path tokenizer.
// ----------------------------------------------------------------------------
package pet_pkg;

    // Build-time limits and the hard caps of the record fields.
    localparam int MAX_CHARS    = 256;
    localparam int MAX_SEGMENTS = 16;
    localparam int CHAR_CAP     = (MAX_CHARS < 256) ? MAX_CHARS : 256;
    localparam int SEG_CAP      = (MAX_SEGMENTS < 16) ? MAX_SEGMENTS : 16;

    localparam int CFG_INDEX_W  = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MAX_CHARS    = 2'd0,
        REG_MAX_SEGMENTS = 2'd1
    } reg_index_t;

    typedef enum logic [1:0] {
        KIND_ANY  = 2'd0,
        KIND_LIST = 2'd1,
        KIND_DICT = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_RUN   = 2'd0,
        ST_EOS   = 2'd1,
        ST_LIMIT = 2'd2,
        ST_DEPTH = 2'd3
    } status_t;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;

    localparam logic [15:0] NUM_MAX  = 16'hFFFF;

endpackage

// ----- design/pet_char_if.sv -----
// ----------------------------------------------------------------------------
// Character channel
// Valid/ready channel carrying one path character per word.
// ----------------------------------------------------------------------------
interface pet_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink (input valid, input ch, input last, output ready);
endinterface

// ----- design/pet_seg_if.sv -----
// ----------------------------------------------------------------------------
// Segment record channel
// Valid/ready channel carrying one segment record per word.
// ----------------------------------------------------------------------------
interface pet_seg_if;
    logic               valid;
    logic               ready;
    logic               seg_valid;
    logic [3:0]         seg_number;
    logic [1:0]         seg_kind;
    logic [7:0]         seg_start;
    logic [8:0]         seg_length;
    logic signed [16:0] seg_numeric;
    logic               taken;
    logic [1:0]         status;
    logic               path_end;

    modport source (
        output valid, output seg_valid, output seg_number, output seg_kind,
        output seg_start, output seg_length, output seg_numeric, output taken,
        output status, output path_end, input ready
    );
    modport sink (
        input valid, input seg_valid, input seg_number, input seg_kind,
        input seg_start, input seg_length, input seg_numeric, input taken,
        input status, input path_end, output ready
    );
endinterface

// ----- design/pet_cfg_if.sv -----
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface pet_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [8:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- design/path_expression_tokenizer_top.sv -----
// ----------------------------------------------------------------------------
// Path expression tokenizer
// Splits a character stream into path segments and reports the current
// segment record for every character.
// ----------------------------------------------------------------------------
// Pipeline: an accepted character word passes the input register, then the
// record register, a two-stage pipeline. Throughput: one character per cycle
// while the record channel is ready; the segment state updates in one pass.
// Reset: all path state and both pipeline stages clear; the limit registers
// return to 256 characters and 16 segments. Path state also clears after last.
module path_expression_tokenizer_top #(
    parameter int MAX_CHARS    = pet_pkg::MAX_CHARS,
    parameter int MAX_SEGMENTS = pet_pkg::MAX_SEGMENTS
) (
    input  logic clk,
    input  logic rst_n,
    pet_char_if.sink   char_chan,
    pet_seg_if.source  seg_chan,
    pet_cfg_if.sink    cfg_chan
);
    import pet_pkg::*;

    // Hard caps of the limits, bounded by the record field widths.
    localparam int CHAR_LIMIT_CAP = (MAX_CHARS < 256) ? MAX_CHARS : 256;
    localparam int SEG_LIMIT_CAP  = (MAX_SEGMENTS < 16) ? MAX_SEGMENTS : 16;

    // Configuration registers.
    logic [8:0] max_chars_reg;
    logic [4:0] max_segs_reg;

    // Input stage.
    logic       ivld_reg;
    logic [7:0] ich_reg;
    logic       ilast_reg;

    // Path state.
    logic [8:0]  pos_reg, pos_next;
    logic        have_reg, have_next;
    logic [3:0]  count_reg, count_next;
    logic        brk_reg, brk_next;
    kind_t       nkind_reg, nkind_next;
    kind_t       ckind_reg, ckind_next;
    logic [7:0]  cstart_reg, cstart_next;
    logic [8:0]  clen_reg, clen_next;
    logic [15:0] cval_reg, cval_next;
    logic        dlive_reg, dlive_next;
    status_t     stop_reg, stop_next;
    logic        taken_next;

    // Record stage.
    logic               ovld_reg;
    logic               o_segv_reg;
    logic [3:0]         o_num_reg;
    logic [1:0]         o_kind_reg;
    logic [7:0]         o_start_reg;
    logic [8:0]         o_len_reg;
    logic signed [16:0] o_numeric_reg;
    logic               o_taken_reg;
    logic [1:0]         o_status_reg;
    logic               o_end_reg;

    logic       out_free;
    logic       step;
    logic [8:0] char_lim;
    logic [4:0] seg_lim;
    logic [4:0] new_num;
    logic [19:0] val_wide;
    logic        is_digit;

    assign out_free = !ovld_reg || seg_chan.ready;
    assign step     = ivld_reg && out_free;

    assign char_chan.ready = !ivld_reg || out_free;
    assign cfg_chan.ready  = 1'b1;

    assign char_lim = (max_chars_reg > 9'(CHAR_LIMIT_CAP)) ? 9'(CHAR_LIMIT_CAP) : max_chars_reg;
    assign seg_lim  = (max_segs_reg > 5'(SEG_LIMIT_CAP)) ? 5'(SEG_LIMIT_CAP) : max_segs_reg;
    assign new_num  = have_reg ? ({1'b0, count_reg} + 5'd1) : 5'd0;
    assign is_digit = (ich_reg inside {[CH_0:CH_9]});

    always_comb
    begin
        pos_next    = pos_reg;
        have_next   = have_reg;
        count_next  = count_reg;
        brk_next    = brk_reg;
        nkind_next  = nkind_reg;
        ckind_next  = ckind_reg;
        cstart_next = cstart_reg;
        clen_next   = clen_reg;
        cval_next   = cval_reg;
        dlive_next  = dlive_reg;
        stop_next   = stop_reg;
        taken_next  = 1'b0;
        val_wide    = 20'(cval_reg) * 20'd10 + 20'(4'(ich_reg - CH_0));

        if (stop_reg == ST_RUN)
        begin
            if (pos_reg >= char_lim)
            begin
                stop_next = ST_LIMIT;
            end
            else if (ich_reg == CH_NUL)
            begin
                stop_next = ST_EOS;
            end
            else if (ich_reg == CH_DOT)
            begin
                brk_next   = 1'b1;
                nkind_next = KIND_ANY;
                taken_next = 1'b1;
            end
            else if (ich_reg == CH_LBRACK)
            begin
                brk_next   = 1'b1;
                nkind_next = KIND_LIST;
                taken_next = 1'b1;
            end
            else if (ich_reg == CH_LBRACE)
            begin
                brk_next   = 1'b1;
                nkind_next = KIND_DICT;
                taken_next = 1'b1;
            end
            else if ((nkind_reg == KIND_LIST && ich_reg == CH_RBRACK) ||
                     (nkind_reg == KIND_DICT && ich_reg == CH_RBRACE))
            begin
                brk_next   = 1'b1;
                nkind_next = KIND_ANY;
                taken_next = 1'b1;
            end
            else
            begin
                // A plain character either opens a segment or extends the current one.
                if (!have_reg || brk_reg)
                begin
                    if (new_num >= seg_lim)
                    begin
                        stop_next = ST_DEPTH;
                    end
                    else
                    begin
                        count_next  = new_num[3:0];
                        have_next   = 1'b1;
                        brk_next    = 1'b0;
                        ckind_next  = nkind_reg;
                        cstart_next = pos_reg[7:0];
                        clen_next   = 9'd1;
                        taken_next  = 1'b1;
                        // A fresh segment starts its value from a leading digit alone, else it is non-numeric.
                        if (is_digit)
                        begin
                            cval_next  = 16'(4'(ich_reg - CH_0));
                            dlive_next = 1'b1;
                        end
                        else
                        begin
                            cval_next  = '0;
                            dlive_next = 1'b0;
                        end
                    end
                end
                else
                begin
                    clen_next  = clen_reg + 9'd1;
                    taken_next = 1'b1;
                    if (dlive_reg)
                    begin
                        if (is_digit)
                        begin
                            cval_next = (val_wide > 20'(NUM_MAX)) ? NUM_MAX : val_wide[15:0];
                        end
                        else
                        begin
                            dlive_next = 1'b0;
                        end
                    end
                end
            end
            if (taken_next)
            begin
                pos_next = pos_reg + 9'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_chars_reg <= 9'(256);
            max_segs_reg  <= 5'd16;
        end
        else if (cfg_chan.valid && cfg_chan.ready)
        begin
            case (cfg_chan.index)
                REG_MAX_CHARS:    max_chars_reg <= cfg_chan.data;
                REG_MAX_SEGMENTS: max_segs_reg  <= cfg_chan.data[4:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ivld_reg <= 1'b0;
        end
        else if (char_chan.ready)
        begin
            ivld_reg <= char_chan.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_chan.valid && char_chan.ready)
        begin
            ich_reg   <= char_chan.ch;
            ilast_reg <= char_chan.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            have_reg   <= 1'b0;
            count_reg  <= '0;
            brk_reg    <= 1'b0;
            nkind_reg  <= KIND_ANY;
            ckind_reg  <= KIND_ANY;
            cstart_reg <= '0;
            clen_reg   <= '0;
            cval_reg   <= '0;
            dlive_reg  <= 1'b1;
            stop_reg   <= ST_RUN;
        end
        else if (step)
        begin
            if (ilast_reg)
            begin
                pos_reg    <= '0;
                have_reg   <= 1'b0;
                count_reg  <= '0;
                brk_reg    <= 1'b0;
                nkind_reg  <= KIND_ANY;
                ckind_reg  <= KIND_ANY;
                cstart_reg <= '0;
                clen_reg   <= '0;
                cval_reg   <= '0;
                dlive_reg  <= 1'b1;
                stop_reg   <= ST_RUN;
            end
            else
            begin
                pos_reg    <= pos_next;
                have_reg   <= have_next;
                count_reg  <= count_next;
                brk_reg    <= brk_next;
                nkind_reg  <= nkind_next;
                ckind_reg  <= ckind_next;
                cstart_reg <= cstart_next;
                clen_reg   <= clen_next;
                cval_reg   <= cval_next;
                dlive_reg  <= dlive_next;
                stop_reg   <= stop_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovld_reg <= 1'b0;
        end
        else if (out_free)
        begin
            ovld_reg <= ivld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            o_segv_reg    <= have_next;
            o_num_reg     <= have_next ? count_next : 4'd0;
            o_kind_reg    <= have_next ? ckind_next : KIND_ANY;
            o_start_reg   <= have_next ? cstart_next : 8'd0;
            o_len_reg     <= have_next ? clen_next : 9'd0;
            o_numeric_reg <= !have_next ? 17'sd0 :
                             dlive_next ? $signed({1'b0, cval_next}) : -17'sd1;
            o_taken_reg   <= taken_next;
            o_status_reg  <= stop_next;
            o_end_reg     <= ilast_reg;
        end
    end

    assign seg_chan.valid       = ovld_reg;
    assign seg_chan.seg_valid   = o_segv_reg;
    assign seg_chan.seg_number  = o_num_reg;
    assign seg_chan.seg_kind    = o_kind_reg;
    assign seg_chan.seg_start   = o_start_reg;
    assign seg_chan.seg_length  = o_len_reg;
    assign seg_chan.seg_numeric = o_numeric_reg;
    assign seg_chan.taken       = o_taken_reg;
    assign seg_chan.status      = o_status_reg;
    assign seg_chan.path_end    = o_end_reg;

    // A taken character never comes with a stop status.
    assert property (@(posedge clk) disable iff (!rst_n)
        seg_chan.valid && seg_chan.taken |-> seg_chan.status == ST_RUN)
        else $error("taken character reported with stop status");

    // Without a segment the record fields read as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        seg_chan.valid && !seg_chan.seg_valid |->
            seg_chan.seg_length == 9'd0 && seg_chan.seg_numeric == 17'sd0)
        else $error("record fields set without a segment");

    // A word in the input stage stays there until the record stage frees up.
    assert property (@(posedge clk) disable iff (!rst_n)
        ivld_reg && !out_free |=> ivld_reg && $stable(ich_reg))
        else $error("input stage lost a word under stall");

    // Path state is back at reset after a final character is processed.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && ilast_reg |=> pos_reg == 9'd0 && !have_reg && stop_reg == ST_RUN)
        else $error("path state not cleared after last");
endmodule

// ----- tb/sv/tb_path_expression_tokenizer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path expression tokenizer testbench
// Streams path characters into the tokenizer and checks every segment record
// against a cycle-free model of the segment state kept in the bench. Covers
// path grammar, end of string, length and depth limits, register settings and
// long runs of random paths with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_path_expression_tokenizer_top;
    import pet_pkg::*;

    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam int DRAIN_CYCLES = 4;

    typedef struct packed {
        logic               seg_valid;
        logic [3:0]         seg_number;
        logic [1:0]         seg_kind;
        logic [7:0]         seg_start;
        logic [8:0]         seg_length;
        logic signed [16:0] seg_numeric;
        logic               taken;
        logic [1:0]         status;
        logic               path_end;
    } seg_record_t;

    logic clk;
    logic rst_n;

    pet_char_if char_bus ();
    pet_seg_if  seg_bus ();
    pet_cfg_if  cfg_bus ();

    path_expression_tokenizer_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_chan (char_bus),
        .seg_chan  (seg_bus),
        .cfg_chan  (cfg_bus)
    );

    // Bench copy of the limit registers and of the per-path segment state.
    logic [8:0] lim_chars_reg;
    logic [4:0] lim_segs_reg;
    logic [8:0] tok_pos;
    logic       tok_have;
    logic [3:0] tok_count;
    logic       tok_break;
    kind_t      tok_next;
    kind_t      tok_kind;
    logic [7:0] tok_start;
    logic [8:0] tok_len;
    int         tok_val;
    logic       tok_digits;
    status_t    tok_stop;

    seg_record_t expected_records[$];

    int  mismatch_count = 0;
    int  records_checked = 0;
    int  chars_sent = 0;
    int  chars_taken = 0;
    int  paths_sent = 0;
    int  reg_writes = 0;
    int  stall_left = 0;
    bit  src_idle_on = 1;
    bit  sink_idle_on = 1;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void clear_path_state();
        tok_pos    = '0;
        tok_have   = 1'b0;
        tok_count  = '0;
        tok_break  = 1'b0;
        tok_next   = KIND_ANY;
        tok_kind   = KIND_ANY;
        tok_start  = '0;
        tok_len    = '0;
        tok_val    = 0;
        tok_digits = 1'b1;
        tok_stop   = ST_RUN;
    endfunction

    // Advances the segment state by one character and returns its record.
    function automatic seg_record_t tokenize_char(input logic [7:0] c, input logic lst);
        seg_record_t rec;
        int          lim_c;
        int          lim_s;
        int          num;
        int          acc;
        logic        took;

        lim_c = (int'(lim_chars_reg) > CHAR_CAP) ? CHAR_CAP : int'(lim_chars_reg);
        lim_s = (int'(lim_segs_reg) > SEG_CAP) ? SEG_CAP : int'(lim_segs_reg);
        took  = 1'b0;

        if (tok_stop == ST_RUN)
        begin
            if (int'(tok_pos) >= lim_c)
                tok_stop = ST_LIMIT;
            else if (c == CH_NUL)
                tok_stop = ST_EOS;
            else
            begin
                if (c == CH_DOT)
                begin
                    tok_break = 1'b1;
                    tok_next  = KIND_ANY;
                    took      = 1'b1;
                end
                else if (c == CH_LBRACK)
                begin
                    tok_break = 1'b1;
                    tok_next  = KIND_LIST;
                    took      = 1'b1;
                end
                else if (c == CH_LBRACE)
                begin
                    tok_break = 1'b1;
                    tok_next  = KIND_DICT;
                    took      = 1'b1;
                end
                else if ((tok_next == KIND_LIST && c == CH_RBRACK) ||
                         (tok_next == KIND_DICT && c == CH_RBRACE))
                begin
                    tok_break = 1'b1;
                    tok_next  = KIND_ANY;
                    took      = 1'b1;
                end
                else
                begin
                    if (!tok_have || tok_break)
                    begin
                        num = tok_have ? int'(tok_count) + 1 : 0;
                        if (num >= lim_s)
                            tok_stop = ST_DEPTH;
                        else
                        begin
                            tok_count  = num[3:0];
                            tok_have   = 1'b1;
                            tok_break  = 1'b0;
                            tok_kind   = tok_next;
                            tok_start  = tok_pos[7:0];
                            tok_len    = 9'd1;
                            tok_val    = 0;
                            tok_digits = 1'b1;
                            took       = 1'b1;
                        end
                    end
                    else
                    begin
                        tok_len = tok_len + 9'd1;
                        took    = 1'b1;
                    end
                    // Digits accumulate most significant first; one non-digit
                    // pins the value at -1 for the rest of the segment.
                    if (took && tok_digits)
                    begin
                        if (c >= CH_0 && c <= CH_9)
                        begin
                            acc     = tok_val * 10 + int'(c - CH_0);
                            tok_val = (acc > int'(NUM_MAX)) ? int'(NUM_MAX) : acc;
                        end
                        else
                        begin
                            tok_val    = -1;
                            tok_digits = 1'b0;
                        end
                    end
                end
                if (took)
                    tok_pos = tok_pos + 9'd1;
            end
        end

        rec = '0;
        if (tok_have)
        begin
            rec.seg_valid   = 1'b1;
            rec.seg_number  = tok_count;
            rec.seg_kind    = tok_kind;
            rec.seg_start   = tok_start;
            rec.seg_length  = tok_len;
            rec.seg_numeric = tok_val[16:0];
        end
        rec.taken    = took;
        rec.status   = tok_stop;
        rec.path_end = lst;

        if (lst)
            clear_path_state();
        return rec;
    endfunction

    task automatic report_mismatch(input string what, input logic [16:0] got,
                                   input logic [16:0] want);
        $display("[%0t] record %0d: %s got %0h, expected %0h",
                 $time, records_checked, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input logic [16:0] got,
                               input logic [16:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // Record checker: every accepted word is matched against the oldest
    // expectation.
    always @(posedge clk)
    begin
        seg_record_t want;
        if (rst_n && seg_bus.valid === 1'b1 && seg_bus.ready === 1'b1)
        begin
            if (expected_records.size() == 0)
                report_mismatch("record with nothing pending, seg_number",
                                17'(seg_bus.seg_number), '0);
            else
            begin
                want = expected_records.pop_front();
                check_field("seg_valid", 17'(seg_bus.seg_valid), 17'(want.seg_valid));
                check_field("seg_number", 17'(seg_bus.seg_number), 17'(want.seg_number));
                check_field("seg_kind", 17'(seg_bus.seg_kind), 17'(want.seg_kind));
                check_field("seg_start", 17'(seg_bus.seg_start), 17'(want.seg_start));
                check_field("seg_length", 17'(seg_bus.seg_length), 17'(want.seg_length));
                check_field("seg_numeric", seg_bus.seg_numeric, want.seg_numeric);
                check_field("taken", 17'(seg_bus.taken), 17'(want.taken));
                check_field("status", 17'(seg_bus.status), 17'(want.status));
                check_field("path_end", 17'(seg_bus.path_end), 17'(want.path_end));
            end
            records_checked++;
        end
    end

    // Record channel back-pressure in random bursts.
    initial
    begin
        seg_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                seg_bus.ready = 1'b0;
                stall_left--;
            end
            else if (sink_idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left    = $urandom_range(1, 11) - 1;
                seg_bus.ready = 1'b0;
            end
            else
                seg_bus.ready = 1'b1;
        end
    end

    task automatic send_char(input logic [7:0] c, input logic lst);
        seg_record_t want;
        int          gap;
        if (src_idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 11);
            repeat (gap)
            begin
                @(negedge clk);
                char_bus.valid = 1'b0;
            end
        end
        @(negedge clk);
        char_bus.valid = 1'b1;
        char_bus.ch    = c;
        char_bus.last  = lst;
        @(posedge clk);
        while (char_bus.ready !== 1'b1)
            @(posedge clk);
        want = tokenize_char(c, lst);
        expected_records.push_back(want);
        chars_sent++;
        if (want.taken)
            chars_taken++;
    endtask

    task automatic send_path(input logic [7:0] chars[$]);
        foreach (chars[i])
            send_char(chars[i], i == chars.size() - 1);
        paths_sent++;
    endtask

    task automatic send_text(input string s);
        logic [7:0] chars[$];
        for (int i = 0; i < s.len(); i++)
            chars.push_back(s[i]);
        send_path(chars);
    endtask

    // Lets the character channel go quiet and every record come back.
    task automatic wait_idle();
        @(negedge clk);
        char_bus.valid = 1'b0;
        while (expected_records.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [8:0] value);
        wait_idle();
        @(negedge clk);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data  = value;
        @(posedge clk);
        while (cfg_bus.ready !== 1'b1)
            @(posedge clk);
        if (idx == REG_MAX_CHARS)
            lim_chars_reg = value;
        else if (idx == REG_MAX_SEGMENTS)
            lim_segs_reg = value[4:0];
        reg_writes++;
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    task automatic test_path_grammar();
        logic [7:0] chars[$];
        // Separators, a list index, a dict key and their matching closers.
        send_text("a.b[3]{key}");
        // Saturating number, then a closer with no open bracket is plain text.
        send_text("99999]");
        chars = '{CH_0, CH_STAR};
        send_path(chars);
    endtask

    task automatic test_stop_conditions();
        logic [7:0] chars[$];
        // Top character code, then end of string; the word after it is ignored.
        chars = '{8'hFF, CH_NUL, 8'h71};
        send_path(chars);
        chars = '{CH_NUL};
        send_path(chars);
    endtask

    task automatic test_register_limits();
        write_reg(REG_MAX_CHARS, 9'd3);
        send_text("abcdef");
        write_reg(REG_MAX_SEGMENTS, 9'h1E2);
        send_text(".a.b.c");
        write_reg(REG_MAX_CHARS, 9'd0);
        send_text("ab");
        write_reg(REG_MAX_SEGMENTS, 9'd0);
        write_reg(REG_MAX_CHARS, 9'h1FF);
        send_text("ab");
        write_reg(REG_MAX_SEGMENTS, 9'd31);
        // A write to an unused index must leave both limits alone.
        write_reg(REG_SPARE, 9'd0);
        send_text("1.2.3[40]");
        write_reg(REG_MAX_CHARS, 9'd1);
        send_text("7x");
        write_reg(REG_MAX_CHARS, 9'd256);
        write_reg(REG_MAX_SEGMENTS, 9'd16);
    endtask

    task automatic test_random_paths(input int quota);
        logic [7:0] chars[$];
        int         start_sent;
        int         nseg;
        int         len;
        int         mode;
        int         kind;
        start_sent = chars_sent;
        while (chars_sent - start_sent < quota)
        begin
            chars.delete();
            if ($urandom_range(0, 29) == 0)
            begin
                // One long segment that runs near or past the length limit.
                len = $urandom_range(240, 272);
                repeat (len)
                    chars.push_back($urandom_range(0, 1) ?
                                    8'(CH_0 + $urandom_range(0, 9)) :
                                    8'($urandom_range(8'h61, 8'h7A)));
            end
            else
            begin
                nseg = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 19)
                                                   : $urandom_range(1, 5);
                for (int s = 0; s < nseg; s++)
                begin
                    kind = $urandom_range(0, 2);
                    if (s > 0 || $urandom_range(0, 1) == 1)
                        chars.push_back(kind == 1 ? CH_LBRACK :
                                        kind == 2 ? CH_LBRACE : CH_DOT);
                    len  = $urandom_range(1, 6);
                    mode = $urandom_range(0, 3);
                    repeat (len)
                    begin
                        if (mode <= 1)
                            chars.push_back(8'(CH_0 + $urandom_range(0, 9)));
                        else if (mode == 2)
                            chars.push_back(8'($urandom_range(8'h61, 8'h7A)));
                        else
                            chars.push_back(8'($urandom_range(1, 255)));
                    end
                    if (kind == 1 && $urandom_range(0, 3) != 0)
                        chars.push_back(CH_RBRACK);
                    else if (kind == 2 && $urandom_range(0, 3) != 0)
                        chars.push_back(CH_RBRACE);
                end
                if ($urandom_range(0, 9) == 0)
                    chars.push_back($urandom_range(0, 1) ? CH_RBRACK : CH_RBRACE);
                if ($urandom_range(0, 14) == 0)
                    chars.insert($urandom_range(0, chars.size() - 1), CH_NUL);
            end
            send_path(chars);
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        char_bus.valid = 1'b0;
        char_bus.ch    = '0;
        char_bus.last  = 1'b0;
        cfg_bus.valid  = 1'b0;
        cfg_bus.index  = '0;
        cfg_bus.data   = '0;
        lim_chars_reg  = 9'd256;
        lim_segs_reg   = 5'd16;
        clear_path_state();
        clk = 1'b0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_path_grammar();
        test_stop_conditions();
        test_register_limits();

        test_random_paths(250);
        write_reg(REG_MAX_CHARS, 9'($urandom_range(1, 40)));
        write_reg(REG_MAX_SEGMENTS, 9'($urandom_range(1, 6)));
        test_random_paths(200);
        write_reg(REG_MAX_CHARS, 9'($urandom_range(200, 511)));
        write_reg(REG_MAX_SEGMENTS, 9'($urandom_range(17, 31)));
        test_random_paths(200);
        write_reg(REG_MAX_CHARS, 9'd256);
        write_reg(REG_MAX_SEGMENTS, 9'd16);

        // Final stretch runs at full rate on both channels.
        wait_idle();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        stall_left   = 0;
        test_random_paths(150);

        wait_idle();
        repeat (10) @(posedge clk);
        $display("covered %0d paths, %0d characters (%0d taken), %0d register writes",
                 paths_sent, chars_sent, chars_taken, reg_writes);
        $display("%0d records checked, %0d mismatches", records_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d records outstanding", expected_records.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- files.f -----
design/pet_pkg.sv
design/pet_char_if.sv
design/pet_seg_if.sv
design/pet_cfg_if.sv
design/path_expression_tokenizer_top.sv
tb/sv/tb_path_expression_tokenizer_top.sv
